>>> hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int NUM_COEF_REGS = 6;
   localparam int CSR_IDX_W     = 3;

   // register map of the coefficient port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_T1_T2 = 3'd0,
      CSR_T3_P1 = 3'd1,
      CSR_P2_P3 = 3'd2,
      CSR_P4_P5 = 3'd3,
      CSR_P6_P7 = 3'd4,
      CSR_P8_P9 = 3'd5
   } csr_index_type;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_DIV_ZERO = 1'b1;

   // divider geometry: 64-bit dividend, divisor magnitude at most 2^30
   localparam int DIV_W     = 64;
   localparam int DIV_MAG_W = 31;
   localparam int DIV_STEPS = DIV_W;

   // data that rides along with a transaction through the divider
   typedef struct packed {
      logic signed [31:0] temp;
      logic               zero_div;
   } ptc_side_type;

endpackage

>>> hdl/pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Throughput: one transaction per cycle unless rsp_stall holds a response; the divider is a 64-stage pipeline.
// rsp_stall against a valid response freezes the whole pipeline and raises req_stall.
// Reset clears all valid bits and the six coefficient registers to zero.
// ----------------------------------------------------------------------------
module pressure_temp_compensation
   import ptc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [19:0]          req_raw_pressure,
   input  logic [19:0]          req_raw_temperature,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_temp_hundredths,
   output logic [31:0]          rsp_pressure_q24_8,
   output logic                 rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int FRONT_STAGES = 11;
   localparam int BACK_STAGES  = 5;
   localparam logic [63:0] X1_BIAS   = 64'h0000_8000_0000_0000;
   localparam logic [43:0] NUM_SCALE = 44'd3125;

   // ------------------------------------------------------------------ csr
   logic [31:0] coef_ff [NUM_COEF_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF_REGS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_T1_T2: coef_ff[0] <= csr_wdata;
            CSR_T3_P1: coef_ff[1] <= csr_wdata;
            CSR_P2_P3: coef_ff[2] <= csr_wdata;
            CSR_P4_P5: coef_ff[3] <= csr_wdata;
            CSR_P6_P7: coef_ff[4] <= csr_wdata;
            CSR_P8_P9: coef_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = coef_ff[0][15:0];
   assign t2 = coef_ff[0][31:16];
   assign t3 = coef_ff[1][15:0];
   assign p1 = coef_ff[1][31:16];
   assign p2 = coef_ff[2][15:0];
   assign p3 = coef_ff[2][31:16];
   assign p4 = coef_ff[3][15:0];
   assign p5 = coef_ff[3][31:16];
   assign p6 = coef_ff[4][15:0];
   assign p7 = coef_ff[4][31:16];
   assign p8 = coef_ff[5][15:0];
   assign p9 = coef_ff[5][31:16];

   // ------------------------------------------------------------ flow control
   logic en;
   logic rsp_valid_ff;

   // advance everything unless a finished transaction is held at the output
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // --------------------------------------------------------- front stages
   logic [FRONT_STAGES-1:0] fvld_ff;

   logic [33:0] s1_a1_ff, s1_a1_in, s1_dsq_ff, s1_dsq_in;
   logic [20:0] s1_padc_ff, s1_padc_in;
   logic [17:0] dt1;
   logic [16:0] dd;

   logic [22:0] s2_x1t_ff, s2_x1t_in;
   logic [37:0] s2_pt3_ff, s2_pt3_in;
   logic [21:0] dsr;
   logic [20:0] s2_padc_ff;

   logic [24:0] s3_tfine_ff, s3_tfine_in;
   logic [23:0] x2t;
   logic [20:0] s3_padc_ff;

   logic [25:0] s4_xa_ff, s4_xa_in;
   logic [31:0] s4_temp_ff, s4_temp_in;
   logic [27:0] tf5;
   logic [20:0] s4_padc_ff;

   logic [51:0] s5_xsq_ff, s5_xsq_in;
   logic [41:0] s5_xp5_ff, s5_xp5_in, s5_xp2_ff, s5_xp2_in;
   logic [31:0] s5_temp_ff;
   logic [20:0] s5_padc_ff;

   logic [42:0] s6_m6l_ff, s6_m6l_in, s6_m6h_ff, s6_m6h_in;
   logic [42:0] s6_m3l_ff, s6_m3l_in, s6_m3h_ff, s6_m3h_in;
   logic [42:0] xsq_lo, xsq_hi, p6_w, p3_w;
   logic [41:0] s6_xp5_ff, s6_xp2_ff;
   logic [31:0] s6_temp_ff;
   logic [20:0] s6_padc_ff;

   logic [63:0] s7_x2_ff, s7_x2_in, s7_x1p_ff, s7_x1p_in, y3, y3_sh;
   logic [31:0] s7_temp_ff;
   logic [20:0] s7_padc_ff;

   logic [63:0] s8_n0_ff, s8_n0_in;
   logic [47:0] s8_mpl_ff, s8_mpl_in, mph_w;
   logic [31:0] s8_mph_ff, s8_mph_in;
   logic [31:0] s8_temp_ff;

   logic [63:0] p1_prod;
   logic [30:0] s9_dv_ff, s9_dv_in;
   logic [43:0] s9_nl_ff, s9_nl_in, nh_w;
   logic [31:0] s9_nh_ff, s9_nh_in;
   logic [31:0] s9_temp_ff;

   logic [63:0] s10_num_ff, s10_num_in;
   logic [30:0] s10_mb_ff, s10_mb_in;
   logic        s10_nb_ff, s10_zero_ff;
   logic [31:0] s10_temp_ff;

   logic [63:0]  s11_ma_ff, s11_ma_in;
   logic [30:0]  s11_mb_ff;
   logic         s11_neg_ff, s11_neg_in;
   ptc_side_type s11_side_ff, s11_side_in;

   always_comb begin
      // temperature terms
      dt1        = {1'b0, req_raw_temperature[19:3]} - {1'b0, t1, 1'b0};
      dd         = {1'b0, req_raw_temperature[19:4]} - {1'b0, t1};
      s1_a1_in   = {{16{dt1[17]}}, dt1} * {{18{t2[15]}}, t2};
      s1_dsq_in  = {{17{dd[16]}}, dd} * {{17{dd[16]}}, dd};
      s1_padc_in = 21'h10_0000 - {1'b0, req_raw_pressure};

      s2_x1t_in = s1_a1_ff[33:11];
      dsr       = s1_dsq_ff[33:12];
      s2_pt3_in = {{16{dsr[21]}}, dsr} * {{22{t3[15]}}, t3};

      x2t         = s2_pt3_ff[37:14];
      s3_tfine_in = {{2{s2_x1t_ff[22]}}, s2_x1t_ff} + {x2t[23], x2t};

      s4_xa_in   = {s3_tfine_ff[24], s3_tfine_ff} - 26'd128000;
      tf5        = {{3{s3_tfine_ff[24]}}, s3_tfine_ff}
                   + {s3_tfine_ff[24], s3_tfine_ff, 2'b00} + 28'd128;
      s4_temp_in = {{12{tf5[27]}}, tf5[27:8]};

      // pressure offset and sensitivity terms
      s5_xsq_in = {{26{s4_xa_ff[25]}}, s4_xa_ff} * {{26{s4_xa_ff[25]}}, s4_xa_ff};
      s5_xp5_in = {{16{s4_xa_ff[25]}}, s4_xa_ff} * {{26{p5[15]}}, p5};
      s5_xp2_in = {{16{s4_xa_ff[25]}}, s4_xa_ff} * {{26{p2[15]}}, p2};

      // split the square so the coefficient products stay narrow
      xsq_lo    = {17'b0, s5_xsq_ff[25:0]};
      xsq_hi    = {17'b0, s5_xsq_ff[51:26]};
      p6_w      = {{27{p6[15]}}, p6};
      p3_w      = {{27{p3[15]}}, p3};
      s6_m6l_in = xsq_lo * p6_w;
      s6_m6h_in = xsq_hi * p6_w;
      s6_m3l_in = xsq_lo * p3_w;
      s6_m3h_in = xsq_hi * p3_w;

      s7_x2_in  = ({{21{s6_m6h_ff[42]}}, s6_m6h_ff} << 26)
                  + {{21{s6_m6l_ff[42]}}, s6_m6l_ff}
                  + ({{22{s6_xp5_ff[41]}}, s6_xp5_ff} << 17)
                  + ({{48{p4[15]}}, p4} << 35);
      y3        = ({{21{s6_m3h_ff[42]}}, s6_m3h_ff} << 26)
                  + {{21{s6_m3l_ff[42]}}, s6_m3l_ff};
      y3_sh     = $signed(y3) >>> 8;
      s7_x1p_in = y3_sh + ({{22{s6_xp2_ff[41]}}, s6_xp2_ff} << 12) + X1_BIAS;

      s8_n0_in  = {12'b0, s7_padc_ff, 31'b0} - s7_x2_ff;
      s8_mpl_in = {16'b0, s7_x1p_ff[31:0]} * {32'b0, p1};
      mph_w     = {16'b0, s7_x1p_ff[63:32]} * {32'b0, p1};
      s8_mph_in = mph_w[31:0];

      p1_prod  = {s8_mph_ff, 32'b0} + {16'b0, s8_mpl_ff};
      s9_dv_in = p1_prod[63:33];
      s9_nl_in = {12'b0, s8_n0_ff[31:0]} * NUM_SCALE;
      nh_w     = {12'b0, s8_n0_ff[63:32]} * NUM_SCALE;
      s9_nh_in = nh_w[31:0];

      s10_num_in = {s9_nh_ff, 32'b0} + {20'b0, s9_nl_ff};
      s10_mb_in  = s9_dv_ff[30] ? (31'd0 - s9_dv_ff) : s9_dv_ff;

      s11_ma_in            = s10_num_ff[63] ? (64'd0 - s10_num_ff) : s10_num_ff;
      s11_neg_in           = s10_num_ff[63] ^ s10_nb_ff;
      s11_side_in.temp     = s10_temp_ff;
      s11_side_in.zero_div = s10_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvld_ff <= '0;
      end else if (en) begin
         fvld_ff <= {fvld_ff[FRONT_STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a1_ff    <= s1_a1_in;
         s1_dsq_ff   <= s1_dsq_in;
         s1_padc_ff  <= s1_padc_in;
         s2_x1t_ff   <= s2_x1t_in;
         s2_pt3_ff   <= s2_pt3_in;
         s2_padc_ff  <= s1_padc_ff;
         s3_tfine_ff <= s3_tfine_in;
         s3_padc_ff  <= s2_padc_ff;
         s4_xa_ff    <= s4_xa_in;
         s4_temp_ff  <= s4_temp_in;
         s4_padc_ff  <= s3_padc_ff;
         s5_xsq_ff   <= s5_xsq_in;
         s5_xp5_ff   <= s5_xp5_in;
         s5_xp2_ff   <= s5_xp2_in;
         s5_temp_ff  <= s4_temp_ff;
         s5_padc_ff  <= s4_padc_ff;
         s6_m6l_ff   <= s6_m6l_in;
         s6_m6h_ff   <= s6_m6h_in;
         s6_m3l_ff   <= s6_m3l_in;
         s6_m3h_ff   <= s6_m3h_in;
         s6_xp5_ff   <= s5_xp5_ff;
         s6_xp2_ff   <= s5_xp2_ff;
         s6_temp_ff  <= s5_temp_ff;
         s6_padc_ff  <= s5_padc_ff;
         s7_x2_ff    <= s7_x2_in;
         s7_x1p_ff   <= s7_x1p_in;
         s7_temp_ff  <= s6_temp_ff;
         s7_padc_ff  <= s6_padc_ff;
         s8_n0_ff    <= s8_n0_in;
         s8_mpl_ff   <= s8_mpl_in;
         s8_mph_ff   <= s8_mph_in;
         s8_temp_ff  <= s7_temp_ff;
         s9_dv_ff    <= s9_dv_in;
         s9_nl_ff    <= s9_nl_in;
         s9_nh_ff    <= s9_nh_in;
         s9_temp_ff  <= s8_temp_ff;
         s10_num_ff  <= s10_num_in;
         s10_mb_ff   <= s10_mb_in;
         s10_nb_ff   <= s9_dv_ff[30];
         s10_zero_ff <= (s9_dv_ff == 31'd0);
         s10_temp_ff <= s9_temp_ff;
         s11_ma_ff   <= s11_ma_in;
         s11_mb_ff   <= s10_mb_ff;
         s11_neg_ff  <= s11_neg_in;
         s11_side_ff <= s11_side_in;
      end
   end

   // -------------------------------------------------------------- divider
   logic         div_valid;
   logic [63:0]  div_quot;
   logic         div_neg;
   ptc_side_type div_side;

   ptc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (fvld_ff[FRONT_STAGES-1]),
      .in_dividend  (s11_ma_ff),
      .in_divisor   (s11_mb_ff),
      .in_neg       (s11_neg_ff),
      .in_side      (s11_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quot),
      .out_neg      (div_neg),
      .out_side     (div_side)
   );

   // ----------------------------------------------------------- back stages
   logic [BACK_STAGES-1:0] bvld_ff;

   logic [63:0]  b1_pr_ff, b1_pr_in;
   ptc_side_type b1_side_ff;

   logic [50:0]  ps;
   logic [24:0]  ps_hi;
   logic [25:0]  ps_lo;
   logic [49:0]  b2_hh_ff, b2_hh_in;
   logic [51:0]  b2_hl_ff, b2_hl_in, b2_ll_ff, b2_ll_in;
   logic [48:0]  b2_pl8_ff, b2_pl8_in;
   logic [47:0]  ph8_w;
   logic [31:0]  b2_ph8_ff, b2_ph8_in;
   logic [63:0]  b2_pr_ff;
   ptc_side_type b2_side_ff;

   logic [63:0]  b3_sq_ff, b3_sq_in, b3_d_ff, b3_d_in, d64;
   logic [63:0]  b3_pr_ff;
   ptc_side_type b3_side_ff;

   logic [48:0]  b4_sl_ff, b4_sl_in;
   logic [47:0]  sh_w;
   logic [31:0]  b4_sh_ff, b4_sh_in;
   logic [63:0]  b4_pr_ff, b4_d_ff;
   ptc_side_type b4_side_ff;

   logic [63:0]  q64, qv;
   logic [63:0]  b5_tot_ff, b5_tot_in;
   ptc_side_type b5_side_ff;

   logic [63:0]  res, res_sh;
   logic [31:0]  rsp_press_in;
   logic         rsp_status_in;
   logic [31:0]  rsp_press_ff;
   logic         rsp_status_ff;
   logic [31:0]  rsp_temp_ff;

   always_comb begin
      b1_pr_in = div_neg ? (64'd0 - div_quot) : div_quot;

      // square of pr >>> 13 from a signed high half and an unsigned low half
      ps        = b1_pr_ff[63:13];
      ps_hi     = ps[50:26];
      ps_lo     = ps[25:0];
      b2_hh_in  = {{25{ps_hi[24]}}, ps_hi} * {{25{ps_hi[24]}}, ps_hi};
      b2_hl_in  = {{27{ps_hi[24]}}, ps_hi} * {26'b0, ps_lo};
      b2_ll_in  = {26'b0, ps_lo} * {26'b0, ps_lo};
      b2_pl8_in = {17'b0, b1_pr_ff[31:0]} * {{33{p8[15]}}, p8};
      ph8_w     = {16'b0, b1_pr_ff[63:32]} * {{32{p8[15]}}, p8};
      b2_ph8_in = ph8_w[31:0];

      b3_sq_in = ({{14{b2_hh_ff[49]}}, b2_hh_ff} << 52)
                 + ({{12{b2_hl_ff[51]}}, b2_hl_ff} << 27)
                 + {12'b0, b2_ll_ff};
      d64      = {b2_ph8_ff, 32'b0} + {{15{b2_pl8_ff[48]}}, b2_pl8_ff};
      b3_d_in  = $signed(d64) >>> 19;

      b4_sl_in = {17'b0, b3_sq_ff[31:0]} * {{33{p9[15]}}, p9};
      sh_w     = {16'b0, b3_sq_ff[63:32]} * {{32{p9[15]}}, p9};
      b4_sh_in = sh_w[31:0];

      q64       = {b4_sh_ff, 32'b0} + {{15{b4_sl_ff[48]}}, b4_sl_ff};
      qv        = $signed(q64) >>> 25;
      b5_tot_in = b4_pr_ff + qv + b4_d_ff;

      res_sh = $signed(b5_tot_ff) >>> 8;
      res    = res_sh + ({{48{p7[15]}}, p7} << 4);
      if (b5_side_ff.zero_div) begin
         rsp_press_in  = '0;
         rsp_status_in = STATUS_DIV_ZERO;
      end else begin
         rsp_status_in = STATUS_OK;
         if (res[63]) begin
            rsp_press_in = '0;
         end else if (|res[62:32]) begin
            rsp_press_in = '1;
         end else begin
            rsp_press_in = res[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         bvld_ff      <= {bvld_ff[BACK_STAGES-2:0], div_valid};
         rsp_valid_ff <= bvld_ff[BACK_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_pr_ff      <= b1_pr_in;
         b1_side_ff    <= div_side;
         b2_hh_ff      <= b2_hh_in;
         b2_hl_ff      <= b2_hl_in;
         b2_ll_ff      <= b2_ll_in;
         b2_pl8_ff     <= b2_pl8_in;
         b2_ph8_ff     <= b2_ph8_in;
         b2_pr_ff      <= b1_pr_ff;
         b2_side_ff    <= b1_side_ff;
         b3_sq_ff      <= b3_sq_in;
         b3_d_ff       <= b3_d_in;
         b3_pr_ff      <= b2_pr_ff;
         b3_side_ff    <= b2_side_ff;
         b4_sl_ff      <= b4_sl_in;
         b4_sh_ff      <= b4_sh_in;
         b4_pr_ff      <= b3_pr_ff;
         b4_d_ff       <= b3_d_ff;
         b4_side_ff    <= b3_side_ff;
         b5_tot_ff     <= b5_tot_in;
         b5_side_ff    <= b4_side_ff;
         rsp_press_ff  <= rsp_press_in;
         rsp_status_ff <= rsp_status_in;
         rsp_temp_ff   <= b5_side_ff.temp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_temp_hundredths = rsp_temp_ff;
   assign rsp_pressure_q24_8  = rsp_press_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

>>> hdl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// ----------------------------------------------------------------------------
module ptc_div
   import ptc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [DIV_W-1:0]     in_dividend,
   input  logic [DIV_MAG_W-1:0] in_divisor,
   input  logic                 in_neg,
   input  ptc_side_type         in_side,
   output logic                 out_valid,
   output logic [DIV_W-1:0]     out_quotient,
   output logic                 out_neg,
   output ptc_side_type         out_side
);

   logic [DIV_STEPS-1:0] vld_ff;
   logic [DIV_W-1:0]     acc_ff [DIV_STEPS];
   logic [DIV_MAG_W-1:0] rem_ff [DIV_STEPS];
   logic [DIV_MAG_W-1:0] dvs_ff [DIV_STEPS];
   logic                 neg_ff [DIV_STEPS];
   ptc_side_type         side_ff [DIV_STEPS];

   logic [DIV_W-1:0]     acc_in [DIV_STEPS];
   logic [DIV_MAG_W-1:0] rem_in [DIV_STEPS];

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      logic [DIV_W-1:0]     acc_prev;
      logic [DIV_MAG_W-1:0] rem_prev;
      logic [DIV_MAG_W-1:0] dvs_prev;
      logic [DIV_MAG_W:0]   trial;
      logic [DIV_MAG_W:0]   diff;
      logic                 take;

      if (g == 0) begin : g_first
         assign acc_prev = in_dividend;
         assign rem_prev = '0;
         assign dvs_prev = in_divisor;
      end else begin : g_next
         assign acc_prev = acc_ff[g-1];
         assign rem_prev = rem_ff[g-1];
         assign dvs_prev = dvs_ff[g-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial     = {rem_prev, acc_prev[DIV_W-1]};
      assign diff      = trial - {1'b0, dvs_prev};
      assign take      = (trial >= {1'b0, dvs_prev});
      assign rem_in[g] = take ? diff[DIV_MAG_W-1:0] : trial[DIV_MAG_W-1:0];
      assign acc_in[g] = {acc_prev[DIV_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            acc_ff[i] <= acc_in[i];
            rem_ff[i] <= rem_in[i];
         end
         dvs_ff[0]  <= in_divisor;
         neg_ff[0]  <= in_neg;
         side_ff[0] <= in_side;
         for (int i = 1; i < DIV_STEPS; i++) begin
            dvs_ff[i]  <= dvs_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid    = vld_ff[DIV_STEPS-1];
   assign out_quotient = acc_ff[DIV_STEPS-1];
   assign out_neg      = neg_ff[DIV_STEPS-1];
   assign out_side     = side_ff[DIV_STEPS-1];

endmodule

>>> hdl/ptc_chk.sv
// ----------------------------------------------------------------------------
// ptc_chk
// Port-level checks for the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
module ptc_chk
   import ptc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [19:0]          req_raw_pressure,
   input logic [19:0]          req_raw_temperature,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic signed [31:0]   rsp_temp_hundredths,
   input logic [31:0]          rsp_pressure_q24_8,
   input logic                 rsp_status,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [31:0]          csr_wdata
);

   // no result may be left over from before reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // a held result must back-pressure the request side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while result is held");

   // a divide-by-zero result reports zero pressure
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DIV_ZERO |-> rsp_pressure_q24_8 == 32'd0)
      else $error("error status with nonzero pressure");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pressure_q24_8)
         && $stable(rsp_temp_hundredths) && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind pressure_temp_compensation ptc_chk u_ptc_chk (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_raw_pressure    (req_raw_pressure),
   .req_raw_temperature (req_raw_temperature),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_temp_hundredths (rsp_temp_hundredths),
   .rsp_pressure_q24_8  (rsp_pressure_q24_8),
   .rsp_status          (rsp_status),
   .csr_valid           (csr_valid),
   .csr_ready           (csr_ready),
   .csr_index           (csr_index),
   .csr_wdata           (csr_wdata)
);

>>> tb/pressure_temp_compensation_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation_tb
// Self-checking bench for the pressure/temperature compensation block. Raw
// readings go in under several coefficient sets and idle/stall mixes; a local
// 64-bit integer model predicts each transaction, and a checker compares every
// response against the oldest prediction.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_tb;
   import ptc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 120;

   typedef struct {
      logic signed [31:0] temp;
      logic [31:0]        press;
      logic               status;
   } reading_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [19:0]          req_raw_pressure;
   logic [19:0]          req_raw_temperature;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [31:0]   rsp_temp_hundredths;
   logic [31:0]          rsp_pressure_q24_8;
   logic                 rsp_status;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   logic [31:0] coef_shadow [NUM_COEF_REGS];
   reading_type expected_readings [$];
   int          idle_pct;
   int          stall_pct;
   int          error_count;
   int          readings_sent;
   int          readings_checked;
   int          div_zero_seen;
   int          quiet_cycles;

   pressure_temp_compensation u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // 64-bit wrapping compensation, arithmetic shifts, truncating division
   function automatic reading_type compensate(logic [19:0] raw_p, logic [19:0] raw_t);
      reading_type r;
      longint      adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint      x1, x2, d, tfine, pr, ps, q, num;
      logic [63:0] mag_n, mag_d, quo;
      adc_p = longint'(raw_p);
      adc_t = longint'(raw_t);
      t1 = longint'(coef_shadow[0][15:0]);
      t2 = longint'($signed(coef_shadow[0][31:16]));
      t3 = longint'($signed(coef_shadow[1][15:0]));
      p1 = longint'(coef_shadow[1][31:16]);
      p2 = longint'($signed(coef_shadow[2][15:0]));
      p3 = longint'($signed(coef_shadow[2][31:16]));
      p4 = longint'($signed(coef_shadow[3][15:0]));
      p5 = longint'($signed(coef_shadow[3][31:16]));
      p6 = longint'($signed(coef_shadow[4][15:0]));
      p7 = longint'($signed(coef_shadow[4][31:16]));
      p8 = longint'($signed(coef_shadow[5][15:0]));
      p9 = longint'($signed(coef_shadow[5][31:16]));

      x1 = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = (adc_t >>> 4) - t1;
      x2 = (((d * d) >>> 12) * t3) >>> 14;
      tfine = x1 + x2;
      r.temp = 32'((tfine * 5 + 128) >>> 8);

      x1 = tfine - 128000;
      x2 = x1 * x1 * p6;
      x2 = x2 + ((x1 * p5) <<< 17);
      x2 = x2 + (p4 <<< 35);
      x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
      x1 = (((longint'(1) <<< 47) + x1) * p1) >>> 33;

      r.press = '0;
      r.status = STATUS_OK;
      if (x1 == 0) begin
         r.status = STATUS_DIV_ZERO;
      end else begin
         pr = 1048576 - adc_p;
         num = ((pr <<< 31) - x2) * 3125;
         mag_n = (num < 0) ? 64'(-num) : 64'(num);
         mag_d = (x1 < 0) ? 64'(-x1) : 64'(x1);
         quo = mag_n / mag_d;
         pr = ((num < 0) != (x1 < 0)) ? -longint'(quo) : longint'(quo);
         ps = pr >>> 13;
         q = (p9 * ps * ps) >>> 25;
         d = (p8 * pr) >>> 19;
         pr = ((pr + q + d) >>> 8) + (p7 <<< 4);
         if (pr < 0)
            r.press = '0;
         else if (pr > 64'sd4294967295)
            r.press = 32'hFFFF_FFFF;
         else
            r.press = pr[31:0];
      end
      return r;
   endfunction

   // response-side stall generator
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected response temp=%0d press=%0h status=%0b", $time,
                     rsp_temp_hundredths, rsp_pressure_q24_8, rsp_status);
            error_count++;
         end else begin
            exp_r = expected_readings.pop_front();
            readings_checked++;
            if (rsp_temp_hundredths !== exp_r.temp) begin
               $display("%0t: temp mismatch expected %0d actual %0d", $time,
                        exp_r.temp, rsp_temp_hundredths);
               error_count++;
            end
            if (rsp_pressure_q24_8 !== exp_r.press) begin
               $display("%0t: pressure mismatch expected %0h actual %0h", $time,
                        exp_r.press, rsp_pressure_q24_8);
               error_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $display("%0t: status mismatch expected %0b actual %0b", $time,
                        exp_r.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // watchdog: count cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding",
                  expected_readings.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_reading(logic [19:0] raw_p, logic [19:0] raw_t);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_raw_pressure    <= raw_p;
      req_raw_temperature <= raw_t;
      do @(posedge clock); while (req_stall);
      expected_readings.push_back(compensate(raw_p, raw_t));
      if (expected_readings[$].status == STATUS_DIV_ZERO)
         div_zero_seen++;
      readings_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high so writes can follow back to back; caller drops it
   task automatic write_coef(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_COEF_REGS)
         coef_shadow[idx] = value;
   endtask

   task automatic load_coef_set(logic [31:0] w0, w1, w2, w3, w4, w5);
      wait_idle();
      write_coef(CSR_T1_T2, w0);
      write_coef(CSR_T3_P1, w1);
      write_coef(CSR_P2_P3, w2);
      write_coef(CSR_P4_P5, w3);
      write_coef(CSR_P6_P7, w4);
      write_coef(CSR_P8_P9, w5);
      csr_valid <= 1'b0;
   endtask

   task automatic load_typical_coefs();
      load_coef_set({16'd26435, 16'd27504}, {16'd36477, 16'(-1000)},
                    {16'd3024, 16'(-10685)}, {16'd140, 16'd2855},
                    {16'd15500, 16'(-7)}, {16'd6000, 16'(-14600)});
   endtask

   task automatic send_typical_reading();
      if ($urandom_range(3) == 0)
         send_reading(20'($urandom), 20'($urandom));
      else
         send_reading(20'($urandom_range(450000, 250000)),
                      20'($urandom_range(560000, 480000)));
   endtask

   // zero coefficients after reset: divisor is zero for every reading
   task automatic test_reset_coefs();
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd415148, 20'd519888);
   endtask

   task automatic test_directed_extremes();
      load_typical_coefs();
      send_reading(20'd415148, 20'd519888);
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd0, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'd0);
      send_reading(20'h55555, 20'hAAAAA);
      send_reading(20'hAAAAA, 20'h55555);
      // out-of-range index: write must be dropped
      wait_idle();
      write_coef(3'd6, 32'hFFFF_FFFF);
      write_coef(3'd7, 32'h0000_0000);
      csr_valid <= 1'b0;
      send_reading(20'd415148, 20'd519888);
   endtask

   task automatic test_coef_extremes();
      load_coef_set('1, '1, '1, '1, '1, '1);
      send_reading(20'd0, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'd0);
      load_coef_set({16'h8000, 16'hFFFF}, {16'hFFFF, 16'h8000}, 32'h8000_8000,
                    32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      load_coef_set(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                    32'h7FFF_7FFF, 32'h7FFF_7FFF);
      send_reading(20'd0, 20'hFFFFF);
      send_reading(20'd415148, 20'd519888);
      // T1 high, P1 zero: divisor zero with nonzero temperature
      load_coef_set({16'h7FFF, 16'hFFFF}, 32'h0000_8000, '1, '1, '1, '1);
      send_reading(20'hFFFFF, 20'h12345);
   endtask

   task automatic test_random_phases();
      int phase_idle [4]  = '{0, 46, 0, 33};
      int phase_stall [4] = '{0, 0, 46, 33};
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         idle_pct  = phase_idle[ph];
         stall_pct = phase_stall[ph];
         if (ph == 2)
            load_coef_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            load_typical_coefs();
         for (int n = 0; n < 270; n++) begin
            // hold off until the pipeline has drained once per phase
            if (n == 135)
               wait_idle();
            if (ph == 2)
               send_reading(20'($urandom), 20'($urandom));
            else
               send_typical_reading();
         end
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_raw_pressure    = '0;
      req_raw_temperature = '0;
      rsp_stall           = 1'b0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      idle_pct            = 0;
      stall_pct           = 0;
      error_count         = 0;
      readings_sent       = 0;
      readings_checked    = 0;
      div_zero_seen       = 0;
      for (int i = 0; i < NUM_COEF_REGS; i++)
         coef_shadow[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_coefs();
      test_directed_extremes();
      test_coef_extremes();
      test_random_phases();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d readings, checked %0d responses, %0d with zero divisor",
               readings_sent, readings_checked, div_zero_seen);
      $display("Covered coefficient extremes, ignored indexes and four idle/stall mixes");
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/ptc_pkg.sv
hdl/ptc_div.sv
hdl/pressure_temp_compensation.sv
hdl/ptc_chk.sv
tb/pressure_temp_compensation_tb.sv
